[src/scba_pkg.sv]
// Shared constants for the slab chunk bitmap allocator: field widths,
// status and register codes, and parameter defaults.
// No dependencies.
package scba_pkg;

	// Parameter defaults
	localparam int SLAB_BYTES_DEF = 64 * 1024;
	localparam int MAX_CHUNKS_DEF = 2048;

	// Configuration port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_CHUNK_SIZE = REG_IDX_W'(0);
	localparam int CFG_W     = 16;
	localparam logic [CFG_W-1:0] CHUNK_SIZE_RST = CFG_W'(32);

	// Stream field widths
	localparam int CMD_W       = 1;
	localparam int OFFSET_W    = 16;
	localparam int STATUS_W    = 2;
	localparam int IDX_OUT_W   = 11;
	localparam int COUNT_OUT_W = 12;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 48;

	// Commands
	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DFREE = 2'd3;

endpackage

[src/scba_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module scba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/scba_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// No dependencies; the divisor must hold steady while busy.
module scba_div #(
	parameter int DVD_W = 17,
	parameter int DVS_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;

	logic [DVS_W:0]   trial;
	logic             fits;
	logic [DVS_W:0]   trial_sub;

	// one shift-subtract step
	always_comb begin
		trial     = {rem_q, quo_q[DVD_W-1]};
		fits      = trial >= {1'b0, divisor};
		trial_sub = trial - {1'b0, divisor};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[src/slab_chunk_bitmap_allocator.sv]
// Slab chunk bitmap allocator top level. Uses scba_pkg, scba_ram, scba_div.
// Allocate: reads map words (64-bit at defaults) from the hint word on, writes
//   the updated word back, then loads the result register.
// Free: the bit-serial divider finds the chunk index, then the map bit is cleared.
// One item in flight; the result register frees the input side early.
// Reset clears map (row valid bits), count, hint; chunk_size resets to 32.
// A chunk_size write rebuilds the slab and blocks items until the new chunk total is set.
module slab_chunk_bitmap_allocator #(
	parameter int SLAB_BYTES = scba_pkg::SLAB_BYTES_DEF,
	parameter int MAX_CHUNKS = scba_pkg::MAX_CHUNKS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [scba_pkg::PADDR_W-1:0]      paddr,
	input  logic [scba_pkg::PDATA_W-1:0]      pwdata,
	output logic [scba_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	// command stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [scba_pkg::S_TDATA_W-1:0]    s_tdata,  // [15:0] slab_offset
	input  logic [scba_pkg::CMD_W-1:0]        s_tuser,  // [0] command
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [10:0] chunk_index, [26:11] chunk_offset, [38:27] allocated_count,
	// [39] slab_full, [40] became_available, [41] slab_empty, [47:42] zero
	output logic [scba_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic [scba_pkg::STATUS_W-1:0]     m_tuser   // [1:0] status
);

	import scba_pkg::*;

	localparam int WORD_W  = (MAX_CHUNKS < 64) ? 32 : 64;
	localparam int WORDS   = (MAX_CHUNKS + WORD_W - 1) / WORD_W;
	localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BIT_W   = $clog2(WORD_W);
	localparam int IDX_W   = $clog2(WORDS * WORD_W);
	localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
	localparam int SLAB_W  = $clog2(SLAB_BYTES + 1);
	localparam int DVD_W   = (SLAB_W > OFFSET_W) ? SLAB_W : OFFSET_W;
	localparam int RST_Q   = SLAB_BYTES / 32;
	localparam int RST_TOT = (RST_Q > MAX_CHUNKS) ? MAX_CHUNKS : RST_Q;
	localparam int PAD_W   = M_TDATA_W - (IDX_OUT_W + OFFSET_W + COUNT_OUT_W + 3);
	localparam int FULL_BIT  = IDX_OUT_W + OFFSET_W + COUNT_OUT_W;
	localparam int AVAIL_BIT = FULL_BIT + 1;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_TOT  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_AWR  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FRD  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]           state_q;
	logic [CFG_W-1:0]     chunk_size_q;
	logic [CNT_W-1:0]     total_q;
	logic [CNT_W-1:0]     taken_count_q;
	logic [IDX_W-1:0]     search_start_q;
	logic [WORDS-1:0]     row_vld_q;
	logic [WADDR_W-1:0]   scan_addr_q;
	logic                 rd_vld_s1;
	logic [WADDR_W-1:0]   rd_addr_s1;
	logic                 m_tvalid_q;

	logic [OFFSET_W-1:0]  offset_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     ci_q;
	logic [OFFSET_W-1:0]  base_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 avail_q;
	logic [WORD_W-1:0]    word_q;
	logic [WADDR_W-1:0]   waddr_q;

	logic [STATUS_W-1:0]    out_status_q;
	logic [IDX_OUT_W-1:0]   out_idx_q;
	logic [OFFSET_W-1:0]    out_base_q;
	logic [COUNT_OUT_W-1:0] out_count_q;
	logic                   out_full_q;
	logic                   out_avail_q;
	logic                   out_empty_q;

	// RAM and divider hookup
	logic                 ram_we;
	logic [WADDR_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]    ram_wdata;
	logic                 ram_re;
	logic [WADDR_W-1:0]   ram_raddr;
	logic [WORD_W-1:0]    ram_rdata;
	logic                 div_start;
	logic [DVD_W-1:0]     div_dividend;
	logic                 div_done;
	logic [DVD_W-1:0]     div_q;
	logic [CFG_W-1:0]     div_rem;

	// decode
	logic                 cfg_we;
	logic                 cfg_hit;
	logic                 cs_zero;
	logic                 accept;
	logic                 alloc_go;
	logic                 free_go;
	logic                 alloc_room;
	logic [WADDR_W-1:0]   start_word;
	logic [BIT_W-1:0]     start_bit;
	logic [WORD_W-1:0]    rd_word;
	logic [WORD_W-1:0]    scan_mask;
	logic [WORD_W-1:0]    free_vec;
	logic                 hit;
	logic [BIT_W-1:0]     hit_bit;
	logic [IDX_W-1:0]     cand_idx;
	logic                 cand_ok;
	logic                 last_word;
	logic                 scan_hit;
	logic                 scan_miss;
	logic                 ci_ok;
	logic [IDX_W-1:0]     ci_idx;
	logic [BIT_W-1:0]     fbit;
	logic                 fbit_set;
	logic                 out_load;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready;
	assign cfg_hit = cfg_we && (paddr[PADDR_W-1:2] == REG_CHUNK_SIZE);
	assign prdata  = (paddr[PADDR_W-1:2] == REG_CHUNK_SIZE) ? PDATA_W'(chunk_size_q) : '0;

	// command decode
	assign cs_zero    = chunk_size_q == '0;
	assign s_tready   = (state_q == S_IDLE) && !cfg_we;
	assign accept     = s_tvalid && s_tready;
	assign alloc_go   = accept && (s_tuser == CMD_ALLOC);
	assign free_go    = accept && (s_tuser == CMD_FREE);
	assign alloc_room = 32'(taken_count_q) < 32'(total_q);
	assign start_word = WADDR_W'(search_start_q >> BIT_W);
	assign start_bit  = search_start_q[BIT_W-1:0];

	// map word as read; rows not written since the last rebuild read as free
	assign rd_word   = row_vld_q[rd_addr_s1] ? ram_rdata : '0;
	assign scan_mask = (rd_addr_s1 == start_word) ? ~({WORD_W{1'b1}} << start_bit) : '0;
	assign free_vec  = ~(rd_word | scan_mask);

	// lowest free bit of the word
	always_comb begin
		hit     = 1'b0;
		hit_bit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				hit     = 1'b1;
				hit_bit = BIT_W'(i);
			end
		end
	end

	assign cand_idx  = (IDX_W'(rd_addr_s1) << BIT_W) | IDX_W'(hit_bit);
	assign cand_ok   = hit && (32'(cand_idx) < 32'(total_q));
	assign last_word = rd_addr_s1 == WADDR_W'(WORDS - 1);
	assign scan_hit  = (state_q == S_SCAN) && rd_vld_s1 && cand_ok;
	assign scan_miss = (state_q == S_SCAN) && rd_vld_s1 && !cand_ok && (hit || last_word);

	// free path decode
	assign ci_ok    = div_q < DVD_W'(total_q);
	assign ci_idx   = IDX_W'(div_q);
	assign fbit     = ci_q[BIT_W-1:0];
	assign fbit_set = rd_word[fbit];
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	// map RAM access
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = scan_addr_q;
		if (state_q == S_SCAN) begin
			ram_re = 1'b1;
		end else if ((state_q == S_DIV) && div_done && ci_ok) begin
			ram_re    = 1'b1;
			ram_raddr = WADDR_W'(ci_idx >> BIT_W);
		end
	end

	assign ram_we    = (state_q == S_AWR) || ((state_q == S_FRD) && fbit_set);
	assign ram_waddr = (state_q == S_AWR) ? waddr_q : rd_addr_s1;
	assign ram_wdata = (state_q == S_AWR) ? word_q : (rd_word & ~(WORD_W'(1) << fbit));

	// divider: chunk total on rebuild, chunk index on free
	assign div_start    = (cfg_hit && (pwdata[CFG_W-1:0] != '0)) || (free_go && !cs_zero);
	assign div_dividend = cfg_hit ? DVD_W'(SLAB_BYTES) : DVD_W'(s_tdata);

	scba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORDS),
		.AW    (WADDR_W)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	scba_div #(
		.DVD_W (DVD_W),
		.DVS_W (CFG_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (chunk_size_q),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_rem)
	);

	// sequencer and slab state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			chunk_size_q   <= CHUNK_SIZE_RST;
			total_q        <= CNT_W'(RST_TOT);
			taken_count_q  <= '0;
			search_start_q <= '0;
			row_vld_q      <= '0;
			scan_addr_q    <= '0;
			rd_vld_s1      <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (alloc_go) begin
						state_q     <= alloc_room ? S_SCAN : S_DONE;
						scan_addr_q <= start_word;
					end else if (free_go) begin
						state_q <= cs_zero ? S_DONE : S_DIV;
					end
				end
				S_TOT: begin
					if (div_done) begin
						total_q <= (32'(div_q) > 32'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS)
						                                         : CNT_W'(div_q);
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						state_q <= S_AWR;
					end else if (scan_miss) begin
						state_q <= S_DONE;
					end else if (scan_addr_q != WADDR_W'(WORDS - 1)) begin
						scan_addr_q <= scan_addr_q + WADDR_W'(1);
					end
				end
				S_AWR: begin
					row_vld_q[waddr_q] <= 1'b1;
					taken_count_q      <= taken_count_q + CNT_W'(1);
					search_start_q     <= idx_q;
					state_q            <= S_DONE;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= ci_ok ? S_FRD : S_DONE;
					end
				end
				S_FRD: begin
					if (fbit_set) begin
						if (taken_count_q != '0) begin
							taken_count_q <= taken_count_q - CNT_W'(1);
						end
						if (ci_q < search_start_q) begin
							search_start_q <= ci_q;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// chunk_size write rebuilds the slab
			if (cfg_hit) begin
				chunk_size_q   <= pwdata[CFG_W-1:0];
				taken_count_q  <= '0;
				search_start_q <= '0;
				row_vld_q      <= '0;
				if (pwdata[CFG_W-1:0] == '0) begin
					total_q <= '0;
					state_q <= S_IDLE;
				end else begin
					state_q <= S_TOT;
				end
			end
		end
	end

	// per-item datapath
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_addr_s1 <= ram_raddr;
		end
		if (accept) begin
			offset_q <= s_tdata[OFFSET_W-1:0];
			status_q <= (s_tuser == CMD_FREE) ? ST_RANGE : ST_FULL;
			idx_q    <= '0;
			base_q   <= '0;
			avail_q  <= 1'b0;
		end
		// allocate: capture the updated word
		if (scan_hit) begin
			word_q  <= rd_word | (WORD_W'(1) << hit_bit);
			waddr_q <= rd_addr_s1;
			idx_q   <= cand_idx;
		end
		if (scan_miss) begin
			status_q <= ST_FULL;
		end
		if (state_q == S_AWR) begin
			base_q   <= OFFSET_W'(idx_q * chunk_size_q);
			status_q <= ST_OK;
		end
		// free: chunk base is offset minus remainder
		if ((state_q == S_DIV) && div_done && ci_ok) begin
			ci_q   <= ci_idx;
			base_q <= offset_q - div_rem;
		end
		if (state_q == S_FRD) begin
			idx_q    <= ci_q;
			status_q <= fbit_set ? ST_OK : ST_DFREE;
			avail_q  <= fbit_set && (taken_count_q == total_q);
		end
		// result register
		if (out_load) begin
			out_status_q <= status_q;
			out_idx_q    <= IDX_OUT_W'(idx_q);
			out_base_q   <= base_q;
			out_count_q  <= COUNT_OUT_W'(taken_count_q);
			out_full_q   <= taken_count_q == total_q;
			out_avail_q  <= avail_q;
			out_empty_q  <= taken_count_q == '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_empty_q, out_avail_q, out_full_q,
	                   out_count_q, out_base_q, out_idx_q};

	// checks
	a_ram_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("map RAM read and write in the same cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(taken_count_q) <= 32'(total_q))
		else $error("taken count above chunk total");

	a_hint_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(search_start_q) <= 32'(total_q))
		else $error("search hint beyond chunk total");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_FULL)) |-> m_tdata[FULL_BIT])
		else $error("full status without slab_full");

	a_avail_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[AVAIL_BIT]) |-> ((m_tuser == ST_OK) && !m_tdata[FULL_BIT]))
		else $error("became_available on a failed or full result");

endmodule
